[hw/rtl/lpbw_pkg.sv]
package lpbw_pkg;

    localparam int SAMPLE_W = 8;
    localparam int THRESH_W = 8;
    localparam int LEN_W    = 11;

    // a sample counts as +1 only when strictly above this after reset
    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd8;

endpackage

[hw/rtl/lpbw_in_if.sv]
interface lpbw_in_if;

    logic                              valid;
    logic                              ready;
    logic [lpbw_pkg::SAMPLE_W-1:0]     sample_value;
    logic                              start_req;

    modport source (output valid, output sample_value, output start_req, input ready);
    modport sink   (input valid, input sample_value, input start_req, output ready);

endinterface

[hw/rtl/lpbw_out_if.sv]
interface lpbw_out_if;

    logic                          valid;
    logic                          ready;
    logic [lpbw_pkg::LEN_W-1:0]    best_length;
    logic                          overflow;

    modport source (output valid, output best_length, output overflow, input ready);
    modport sink   (input valid, input best_length, input overflow, output ready);

endinterface

[hw/rtl/lpbw_cfg_if.sv]
interface lpbw_cfg_if;

    logic                              valid;
    logic                              ready;
    logic [lpbw_pkg::THRESH_W-1:0]     threshold;

    modport source (output valid, output threshold, input ready);
    modport sink   (input valid, input threshold, output ready);

endinterface

[hw/rtl/lpbw_table.sv]
module lpbw_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds between reads so a stalled consumer keeps it
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/longest_positive_balance_window.sv]
// channel   dir  payload                          handshake
// i_in      in   sample_value[7:0], start_req     valid/ready
// o_out     out  best_length[10:0], overflow      valid/ready
// i_cfg     in   threshold[7:0]                   valid/ready, ready always high
//
// one request per cycle while i_in.ready is high; a result passes both stages
// stage one updates balance and position in flops and reads or writes the
// first-reach table; stage two settles the best length from the table read
// synchronous active-low reset clears the sequence and sets threshold to 8,
// the table is not cleared
// i_in.ready drops only while stage one and the output register both hold an
// item and o_out.ready is low
module longest_positive_balance_window #(
    parameter int MAX_LEN = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpbw_in_if.sink       i_in,
    lpbw_out_if.source    o_out,
    lpbw_cfg_if.sink      i_cfg
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int BW = PW + 1;
    localparam int AW = $clog2(MAX_LEN);
    localparam logic signed [BW-1:0] ZERO_BAL = '0;
    localparam logic signed [BW-1:0] ONE_BAL  = BW'(1);
    localparam logic [PW-1:0]        FULL_POS = PW'(MAX_LEN);

    logic [lpbw_pkg::THRESH_W-1:0] r_threshold;

    logic [PW-1:0]        r_position;
    logic signed [BW-1:0] r_balance;
    logic signed [BW-1:0] r_lowest;
    logic [PW-1:0]        r_best;

    logic          r_s1_valid;
    logic          r_s1_start;
    logic          r_s1_ovf;
    logic          r_s1_pos_bal;
    logic          r_s1_rd;
    logic [AW-1:0] r_s1_idx;

    logic          r_out_valid;
    logic [PW-1:0] r_out_best;
    logic          r_out_ovf;

    logic                 accept;
    logic                 s1_go;
    logic [PW-1:0]        base_pos;
    logic signed [BW-1:0] base_bal;
    logic signed [BW-1:0] base_low;
    logic                 full;
    logic signed [BW-1:0] n_balance;
    logic signed [BW-1:0] bal_m1;
    logic signed [BW-1:0] neg_bal;
    logic signed [BW-1:0] neg_bal_m1;
    logic                 rd_need;
    logic                 wr_need;
    logic [AW-1:0]        rd_data;
    logic [PW-1:0]        prev_best;
    logic [PW-1:0]        cand;
    logic [AW-1:0]        span;
    logic [PW-1:0]        n_best;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= lpbw_pkg::THRESH_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_threshold <= i_cfg.threshold;
        end
    end

    // stage one: balance update and table access
    assign s1_go      = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_go;
    assign accept     = i_in.valid && i_in.ready;

    assign base_pos = i_in.start_req ? '0 : r_position;
    assign base_bal = i_in.start_req ? ZERO_BAL : r_balance;
    assign base_low = i_in.start_req ? ZERO_BAL : r_lowest;
    assign full     = (base_pos == FULL_POS);

    assign n_balance  = (i_in.sample_value > r_threshold) ? base_bal + ONE_BAL
                                                          : base_bal - ONE_BAL;
    assign bal_m1     = n_balance - ONE_BAL;
    assign neg_bal    = ZERO_BAL - n_balance;
    assign neg_bal_m1 = neg_bal - ONE_BAL;

    // the window start lies after the first reach of balance - 1, if it was reached
    assign rd_need = !full && !(n_balance > ZERO_BAL) && (bal_m1 >= base_low);
    assign wr_need = !full && (n_balance < base_low);

    lpbw_table #(
        .DEPTH (MAX_LEN),
        .AW    (AW),
        .DW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (accept && wr_need),
        .i_wr_addr (neg_bal_m1[AW-1:0]),
        .i_wr_data (base_pos[AW-1:0]),
        .i_rd_en   (accept && rd_need),
        .i_rd_addr (neg_bal[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_balance  <= ZERO_BAL;
            r_lowest   <= ZERO_BAL;
        end else if (accept && !full) begin
            r_position <= base_pos + PW'(1);
            r_balance  <= n_balance;
            r_lowest   <= wr_need ? n_balance : base_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_start   <= i_in.start_req;
            r_s1_ovf     <= full;
            r_s1_pos_bal <= !full && (n_balance > ZERO_BAL);
            r_s1_rd      <= rd_need;
            r_s1_idx     <= base_pos[AW-1:0];
        end
    end

    // stage two: best length
    assign prev_best = r_s1_start ? '0 : r_best;
    assign span      = r_s1_idx - rd_data;

    always_comb begin
        priority if (r_s1_pos_bal) begin
            cand = PW'(r_s1_idx) + PW'(1);
        end else if (r_s1_rd) begin
            cand = PW'(span);
        end else begin
            cand = '0;
        end
    end

    assign n_best = (cand > prev_best) ? cand : prev_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_go) begin
            r_best      <= n_best;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_go) begin
            r_out_best <= n_best;
            r_out_ovf  <= r_s1_ovf;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.best_length = lpbw_pkg::LEN_W'(r_out_best);
    assign o_out.overflow    = r_out_ovf;

    // checks
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= FULL_POS)
        else $error("position beyond capacity");

    a_low_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_lowest > ZERO_BAL) && (r_balance >= r_lowest))
        else $error("lowest balance out of order");

    a_entry_older: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_rd) |-> (rd_data < r_s1_idx))
        else $error("table entry not older than current position");

    a_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted request lost before stage two");

endmodule

[bench/lpbw_tb_pkg.sv]
`timescale 1ns / 1ps

package lpbw_tb_pkg;

    localparam int SEQ_CAP = 1024;
    localparam int LEN_W   = lpbw_pkg::LEN_W;

    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic             overflow;
    } t_window_result;

    class t_window_scoreboard;

        logic [lpbw_pkg::THRESH_W-1:0] threshold;
        int             run_pos;
        int             run_balance;
        int             low_mark;
        int             best_len;
        // entry k: position where the balance first fell to -(k+1)
        int             first_reach[SEQ_CAP];
        t_window_result expected_q[$];
        int             errors;

        function new();
            threshold = lpbw_pkg::THRESH_RESET;
            errors    = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            run_pos     = 0;
            run_balance = 0;
            low_mark    = 0;
            best_len    = 0;
        endfunction

        function void set_threshold(logic [lpbw_pkg::THRESH_W-1:0] value);
            threshold = value;
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction

        function void note_request(logic [lpbw_pkg::SAMPLE_W-1:0] sample, logic start);
            t_window_result r;
            int             span;
            if (start)
                clear_sequence();
            r.overflow = 1'b0;
            if (run_pos >= SEQ_CAP) begin
                r.overflow = 1'b1;
            end else begin
                run_balance += (sample > threshold) ? 1 : -1;
                if (run_balance > 0) begin
                    if (run_pos + 1 > best_len)
                        best_len = run_pos + 1;
                end else begin
                    // window starts just after the first reach of balance - 1
                    if (run_balance - 1 >= low_mark) begin
                        span = run_pos - first_reach[-run_balance];
                        if (span > best_len)
                            best_len = span;
                    end
                    if (run_balance < low_mark) begin
                        first_reach[-run_balance - 1] = run_pos;
                        low_mark = run_balance;
                    end
                end
                run_pos++;
            end
            r.best_length = LEN_W'(best_len);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [LEN_W-1:0] best_length, logic overflow);
            t_window_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result best_length=%0d overflow=%0b",
                         $time, best_length, overflow);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (best_length !== exp_r.best_length) begin
                $display("%0t: best_length mismatch, expected %0d, actual %0d",
                         $time, exp_r.best_length, best_length);
                errors++;
            end
            if (overflow !== exp_r.overflow) begin
                $display("%0t: overflow mismatch, expected %0b, actual %0b",
                         $time, exp_r.overflow, overflow);
                errors++;
            end
        endfunction

    endclass

endpackage

[bench/tb_longest_positive_balance_window.sv]
`timescale 1ns / 1ps

module tb_longest_positive_balance_window;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpbw_in_if  in_if();
    lpbw_out_if out_if();
    lpbw_cfg_if cfg_if();

    longest_positive_balance_window #(.MAX_LEN(lpbw_tb_pkg::SEQ_CAP)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    lpbw_tb_pkg::t_window_scoreboard board = new();

    logic [lpbw_pkg::THRESH_W-1:0] cur_thr = lpbw_pkg::THRESH_RESET;
    int send_burst = 0;
    int recv_burst = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // wait cycles before the next request or result; now and then a run with none
    function automatic int draw_wait(ref int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] pick_sample(bit up);
        if (up && cur_thr != 8'd255)
            return 8'($urandom_range(255, int'(cur_thr) + 1));
        if (!up)
            return 8'($urandom_range(int'(cur_thr), 0));
        return 8'($urandom_range(255, 0));
    endfunction

    task automatic send_request(input logic [7:0] sample, input logic start);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.sample_value <= sample;
        in_if.start_req    <= start;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_request(sample, start);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (board.waiting() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] value);
        drain();
        cfg_if.valid     <= 1'b1;
        cfg_if.threshold <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        board.set_threshold(value);
        cur_thr = value;
    endtask

    // falls for n_down samples, then rises past capacity, then restarts on a
    // full sequence
    task automatic run_full_sequence(input int n_down);
        for (int n = 0; n < lpbw_tb_pkg::SEQ_CAP + 6; n++)
            send_request(pick_sample(n >= n_down), n == 0);
        send_request(pick_sample(1'b1), 1'b1);
        send_request(pick_sample(1'b0), 1'b0);
    endtask

    task automatic run_sequences(input int total);
        int left;
        int seq_len;
        int up_pct;
        left = total;
        while (left > 0) begin
            seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200)
                                                  : $urandom_range(1, 40);
            up_pct  = $urandom_range(0, 100);
            for (int n = 0; n < seq_len && left > 0; n++) begin
                if ($urandom_range(0, 24) == 0)
                    send_request(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
                else
                    send_request(pick_sample($urandom_range(99, 0) < up_pct), n == 0);
                left--;
            end
        end
    endtask

    initial begin
        logic [7:0] thr_list[8];
        thr_list = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd0, 8'd0, 8'd0};
        in_if.valid        <= 1'b0;
        in_if.sample_value <= '0;
        in_if.start_req    <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.threshold   <= '0;
        out_if.ready       <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // threshold at its reset value: boundary samples, rises, falls, restarts
        send_request(8'd9,   1'b1);
        send_request(8'd8,   1'b0);
        send_request(8'd0,   1'b0);
        send_request(8'd0,   1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd128, 1'b0);
        send_request(8'd7,   1'b0);
        send_request(8'd0,   1'b1);
        send_request(8'd0,   1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd9,   1'b0);
        send_request(8'd9,   1'b0);
        send_request(8'd8,   1'b1);
        send_request(8'd255, 1'b0);
        send_request(8'd170, 1'b0);
        send_request(8'd85,  1'b0);
        send_request(8'd0,   1'b0);
        send_request(8'd9,   1'b0);

        for (int p = 2; p < 8; p++)
            thr_list[p + 0] = (p >= 5) ? 8'($urandom_range(255, 0)) : thr_list[p];

        foreach (thr_list[p]) begin
            write_threshold(thr_list[p]);
            // one sequence past capacity: a deep fall, then a climb to a full window
            if (p == 0)
                run_full_sequence(400);
            run_sequences(8);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int stall;
        int seen;
        seen = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(recv_burst);
            // long hold-off so the block backs up and stalls its input
            if (seen == 200 || seen == 700)
                stall = 150;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            board.check_result(out_if.best_length, out_if.overflow);
            seen++;
        end
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lpbw_pkg.sv
hw/rtl/lpbw_in_if.sv
hw/rtl/lpbw_out_if.sv
hw/rtl/lpbw_cfg_if.sv
hw/rtl/lpbw_table.sv
hw/rtl/longest_positive_balance_window.sv
bench/lpbw_tb_pkg.sv
bench/tb_longest_positive_balance_window.sv
